### rtl/core/assert_macros.svh
// Assertion macros shared by the shader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, checked out of reset.
`define GCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define GCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/gcs_pkg.sv
// Types, constants and the product micro-program for the gradient shader.
`default_nettype none
package gcs_pkg;

	localparam int MAX_STOPS_DEF = 8;
	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int ACC_W   = 106;
	localparam int MAG_W   = 52;
	localparam int ROOT_W  = 53;
	localparam int REM_W   = 56;
	localparam int DIV_W   = 57;
	localparam int FRAC_W  = 17;
	localparam int WT_W    = 19;
	localparam int COL_W   = 32;
	localparam int ENT_W   = FRAC_W + COL_W;
	localparam int IN_W    = 104;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SHADE = 1'b1;

	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_RADIAL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_P0X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P0Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P1X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_P1Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd6;

	localparam logic [1:0] DST_R0 = 2'd0;
	localparam logic [1:0] DST_R1 = 2'd1;
	localparam logic [1:0] DST_R2 = 2'd2;
	localparam logic [1:0] DST_R3 = 2'd3;

	typedef enum logic [2:0] {
		OPD_E0, OPD_E1, OPD_E2, OPD_E3, OPD_E4, OPD_R0, OPD_R1, OPD_R2
	} opnd_t;

	typedef struct packed {
		opnd_t      x;
		opnd_t      y;
		logic [1:0] dst;
		logic       acc;
		logic       sub;
		logic       last;
	} mop_t;

	function automatic mop_t mk_mop(opnd_t x, opnd_t y, logic [1:0] dst, logic acc,
		logic sub, logic last);
		mop_t m;
		m.x = x;
		m.y = y;
		m.dst = dst;
		m.acc = acc;
		m.sub = sub;
		m.last = last;
		return m;
	endfunction

	// Linear: r0 = num, r1 = den. Radial: r0 = a, r1 = h, r2 = c, r3 = h*h - a*c.
	function automatic mop_t mop_get(logic radial, logic [3:0] k);
		mop_t m;
		m = mk_mop(OPD_E0, OPD_E0, DST_R0, 1'b0, 1'b0, 1'b1);
		if (!radial) begin
			case (k)
				4'd0: m = mk_mop(OPD_E0, OPD_E2, DST_R0, 1'b0, 1'b0, 1'b0);
				4'd1: m = mk_mop(OPD_E1, OPD_E3, DST_R0, 1'b1, 1'b0, 1'b0);
				4'd2: m = mk_mop(OPD_E2, OPD_E2, DST_R1, 1'b0, 1'b0, 1'b0);
				4'd3: m = mk_mop(OPD_E3, OPD_E3, DST_R1, 1'b1, 1'b0, 1'b1);
				default: m = mk_mop(OPD_E0, OPD_E0, DST_R0, 1'b0, 1'b0, 1'b1);
			endcase
		end else begin
			case (k)
				4'd0: m = mk_mop(OPD_E0, OPD_E0, DST_R0, 1'b0, 1'b0, 1'b0);
				4'd1: m = mk_mop(OPD_E1, OPD_E1, DST_R0, 1'b1, 1'b0, 1'b0);
				4'd2: m = mk_mop(OPD_E0, OPD_E2, DST_R1, 1'b0, 1'b0, 1'b0);
				4'd3: m = mk_mop(OPD_E1, OPD_E3, DST_R1, 1'b1, 1'b0, 1'b0);
				4'd4: m = mk_mop(OPD_E2, OPD_E2, DST_R2, 1'b0, 1'b0, 1'b0);
				4'd5: m = mk_mop(OPD_E3, OPD_E3, DST_R2, 1'b1, 1'b0, 1'b0);
				4'd6: m = mk_mop(OPD_E4, OPD_E4, DST_R2, 1'b1, 1'b1, 1'b0);
				4'd7: m = mk_mop(OPD_R1, OPD_R1, DST_R3, 1'b0, 1'b0, 1'b0);
				4'd8: m = mk_mop(OPD_R0, OPD_R2, DST_R3, 1'b1, 1'b1, 1'b1);
				default: m = mk_mop(OPD_E0, OPD_E0, DST_R0, 1'b0, 1'b0, 1'b1);
			endcase
		end
		return m;
	endfunction

endpackage
`default_nettype wire

### rtl/core/gcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/gradient_color_shader.sv
// Shader top level: stop table, product sequencer, square root, divider, search and blend.
// A stop write is stored as it is accepted. In a linear or radial shade, the shared
// shift-add multiplier does most of the work, one multiplier bit per step, followed by
// 53 square-root steps (radial only), up to 16 divide steps per quotient, one step per
// stop searched and one blend step per channel. One item is in flight at a time.
// arst_n clears the sequencer, output valid and the configuration; datapath registers
// and the stop table are not cleared.
`default_nettype none
`include "assert_macros.svh"
module gradient_color_shader
	import gcs_pkg::*;
#(
	parameter int MAX_STOPS = MAX_STOPS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DAT_W-1:0]  cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// point_x, point_y, stop_index, stop_position, stop_red, stop_green,
	// stop_blue, stop_alpha, zero pad
	input  wire logic [IN_W-1:0]       s_tdata,
	input  wire logic                  s_tuser,   // opcode
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [COL_W-1:0]           m_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic                       m_tuser    // degenerate
);

	localparam int AW = $clog2(MAX_STOPS);
	localparam int CW = $clog2(MAX_STOPS + 1);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_MSET  = 13'b0000000000010,
		S_MUL   = 13'b0000000000100,
		S_FRAC  = 13'b0000000001000,
		S_SQRT  = 13'b0000000010000,
		S_RDEN  = 13'b0000000100000,
		S_RCMP  = 13'b0000001000000,
		S_DIV   = 13'b0000010000000,
		S_LKA   = 13'b0000100000000,
		S_LKB   = 13'b0001000000000,
		S_LKC   = 13'b0010000000000,
		S_SCAN  = 13'b0100000000000,
		S_BLEND = 13'b1000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0]                mode_q;
	logic signed [COORD_W-1:0] p0x_q, p0y_q, p1x_q, p1y_q;
	logic [COORD_W-2:0]        radius_q;
	logic [CW-1:0]             count_q;

	// input fields
	logic signed [COORD_W-1:0] in_px, in_py;
	logic [2:0]                in_idx;
	logic [FRAC_W-1:0]         in_pos, pos_sat;
	logic [COL_W-1:0]          in_col;

	assign in_px  = $signed(s_tdata[23:0]);
	assign in_py  = $signed(s_tdata[47:24]);
	assign in_idx = s_tdata[50:48];
	assign in_pos = s_tdata[67:51];
	assign in_col = {s_tdata[99:92], s_tdata[91:84], s_tdata[83:76], s_tdata[75:68]};
	assign pos_sat = (in_pos > ONE_Q16) ? ONE_Q16 : in_pos;

	logic in_acc;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;

	// stop table
	logic            ram_we;
	logic [AW-1:0]   ram_raddr;
	logic [ENT_W-1:0] ram_rdata;
	logic [FRAC_W-1:0] rd_pos;
	logic [COL_W-1:0]  rd_col;

	assign ram_we = in_acc && (s_tuser == OP_WRITE) && (32'(in_idx) < MAX_STOPS);
	assign rd_pos = ram_rdata[ENT_W-1:COL_W];
	assign rd_col = ram_rdata[COL_W-1:0];

	gcs_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_STOPS)
	) u_stops (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_idx)),
		.wdata ({pos_sat, in_col}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// geometry and product registers
	logic signed [DIFF_W-1:0] e0_q, e1_q, e2_q, e3_q, e4_q;
	logic                     radial_q;
	logic signed [ACC_W-1:0]  r0_q, r1_q, r2_q, r3_q;
	logic [3:0]               op_q;
	logic signed [ACC_W-1:0]  mcand_q, prod_q;
	logic [MAG_W-1:0]         mplier_q;
	mop_t                     mop;
	logic signed [ACC_W-1:0]  x_val, y_val, dst_val, y_mag;

	assign mop = mop_get(radial_q, op_q);

	always_comb begin
		case (mop.x)
			OPD_E0:  x_val = ACC_W'(e0_q);
			OPD_E1:  x_val = ACC_W'(e1_q);
			OPD_E2:  x_val = ACC_W'(e2_q);
			OPD_E3:  x_val = ACC_W'(e3_q);
			OPD_E4:  x_val = ACC_W'(e4_q);
			OPD_R0:  x_val = r0_q;
			OPD_R1:  x_val = r1_q;
			OPD_R2:  x_val = r2_q;
			default: x_val = '0;
		endcase
		case (mop.y)
			OPD_E0:  y_val = ACC_W'(e0_q);
			OPD_E1:  y_val = ACC_W'(e1_q);
			OPD_E2:  y_val = ACC_W'(e2_q);
			OPD_E3:  y_val = ACC_W'(e3_q);
			OPD_E4:  y_val = ACC_W'(e4_q);
			OPD_R0:  y_val = r0_q;
			OPD_R1:  y_val = r1_q;
			OPD_R2:  y_val = r2_q;
			default: y_val = '0;
		endcase
		case (mop.dst)
			DST_R0:  dst_val = r0_q;
			DST_R1:  dst_val = r1_q;
			DST_R2:  dst_val = r2_q;
			default: dst_val = r3_q;
		endcase
	end

	assign y_mag = y_val[ACC_W-1] ? -y_val : y_val;

	// square root
	logic [ACC_W-1:0]        rad_q;
	logic [REM_W-1:0]        rem_q, rem_sh, trial;
	logic [ROOT_W-1:0]       root_q;
	logic [5:0]              cnt_q;
	logic signed [DIV_W-1:0] den_q;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[ACC_W-1:ACC_W-2]};
	assign trial  = REM_W'({root_q, 2'b01});

	// divider
	logic [DIV_W-1:0]  dnum_q, dden_q, dsh;
	logic [FRAC_W-1:0] dq_q, dq_next, dres;
	logic              dge, dsat, ddone, wdiv_q;

	assign dsh     = {dnum_q[DIV_W-2:0], 1'b0};
	assign dge     = (dsh >= dden_q);
	assign dq_next = {dq_q[FRAC_W-2:0], dge};
	assign dsat    = (cnt_q == '0) && (dnum_q >= dden_q);
	assign ddone   = dsat || (cnt_q == 6'd15);
	assign dres    = dsat ? ONE_Q16 : dq_next;

	// stop search and weight
	logic [FRAC_W-1:0]       at_q, first_pos_q, prev_pos_q;
	logic [COL_W-1:0]        first_col_q, prev_col_q;
	logic [CW-1:0]           idx_q;
	logic signed [WT_W-1:0]  w_off, w_span;
	logic                    w_zero, wrap, bracket;

	assign wrap    = (at_q < first_pos_q) || (at_q > rd_pos);
	assign bracket = (at_q >= prev_pos_q) && (at_q <= rd_pos);

	always_comb begin
		if (state_q == S_LKC) begin
			w_off  = $signed({2'b00, at_q}) + ((at_q < first_pos_q) ?
				$signed({2'b00, ONE_Q16}) : '0) - $signed({2'b00, rd_pos});
			w_span = $signed({2'b00, first_pos_q}) + $signed({2'b00, ONE_Q16})
				- $signed({2'b00, rd_pos});
		end else begin
			w_off  = $signed({2'b00, at_q}) - $signed({2'b00, prev_pos_q});
			w_span = $signed({2'b00, rd_pos}) - $signed({2'b00, prev_pos_q});
		end
	end

	assign w_zero = (w_span <= 0) || (w_off <= 0);

	always_comb begin
		case (state_q)
			S_LKB:   ram_raddr = AW'(count_q - CW'(1));
			S_LKC:   ram_raddr = AW'(1);
			S_SCAN:  ram_raddr = AW'(idx_q + CW'(1));
			default: ram_raddr = '0;
		endcase
	end

	// blend
	logic [COL_W-1:0]        c1_q, c2_q, res_q;
	logic [FRAC_W-1:0]       w_q;
	logic [1:0]              ch_q;
	logic [7:0]              ba, bb, bv;
	logic signed [8:0]       bdiff;
	logic signed [26:0]      bprod;
	logic signed [27:0]      bsum;
	logic                    deg_q, out_valid_q;
	logic [COL_W-1:0]        m_tdata_q;
	logic                    m_tuser_q;

	assign ba    = c1_q[{ch_q, 3'b000} +: 8];
	assign bb    = c2_q[{ch_q, 3'b000} +: 8];
	assign bdiff = $signed({1'b0, bb}) - $signed({1'b0, ba});
	assign bprod = bdiff * $signed({1'b0, w_q});
	assign bsum  = $signed({4'b0000, ba, 16'h0000}) + $signed({bprod[26], bprod})
		+ 28'sd32768;
	assign bv    = bsum[23:16];

	assign m_tvalid = out_valid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mode_q      <= '0;
			p0x_q       <= '0;
			p0y_q       <= '0;
			p1x_q       <= '0;
			p1y_q       <= '0;
			radius_q    <= '0;
			count_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[1:0];
					REG_P0X:    p0x_q    <= $signed(cfg_data);
					REG_P0Y:    p0y_q    <= $signed(cfg_data);
					REG_P1X:    p1x_q    <= $signed(cfg_data);
					REG_P1Y:    p1y_q    <= $signed(cfg_data);
					REG_RADIUS: radius_q <= cfg_data[COORD_W-2:0];
					REG_COUNT:  count_q  <= (32'(cfg_data[7:0]) > MAX_STOPS) ?
						CW'(MAX_STOPS) : CW'(cfg_data[7:0]);
					default: ;
				endcase
			end

			// load the output register from the last blend channel, else drop it when taken
			if ((state_q == S_BLEND) && (ch_q == 2'd3) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc && (s_tuser == OP_SHADE)) begin
						radial_q <= (mode_q == MODE_RADIAL);
						deg_q    <= 1'b0;
						op_q     <= '0;
						if (mode_q == MODE_RADIAL) begin
							e0_q <= DIFF_W'(in_px) - DIFF_W'(p1x_q);
							e1_q <= DIFF_W'(in_py) - DIFF_W'(p1y_q);
						end else begin
							e0_q <= DIFF_W'(in_px) - DIFF_W'(p0x_q);
							e1_q <= DIFF_W'(in_py) - DIFF_W'(p0y_q);
						end
						e2_q <= DIFF_W'(p1x_q) - DIFF_W'(p0x_q);
						e3_q <= DIFF_W'(p1y_q) - DIFF_W'(p0y_q);
						e4_q <= $signed({2'b00, radius_q});
						if (mode_q == MODE_LINEAR || mode_q == MODE_RADIAL) begin
							state_q <= S_MSET;
						end else begin
							c1_q    <= '0;
							c2_q    <= '0;
							w_q     <= '0;
							ch_q    <= '0;
							state_q <= S_BLEND;
						end
					end
				end
				S_MSET: begin
					mcand_q  <= (y_val[ACC_W-1] ^ mop.sub) ? -x_val : x_val;
					mplier_q <= y_mag[MAG_W-1:0];
					prod_q   <= mop.acc ? dst_val : '0;
					state_q  <= S_MUL;
				end
				S_MUL: begin
					if (mplier_q == '0) begin
						case (mop.dst)
							DST_R0:  r0_q <= prod_q;
							DST_R1:  r1_q <= prod_q;
							DST_R2:  r2_q <= prod_q;
							default: r3_q <= prod_q;
						endcase
						if (mop.last) begin
							state_q <= S_FRAC;
						end else begin
							op_q    <= op_q + 4'd1;
							state_q <= S_MSET;
						end
					end else begin
						prod_q   <= prod_q + (mplier_q[0] ? mcand_q : '0);
						mcand_q  <= mcand_q <<< 1;
						mplier_q <= mplier_q >> 1;
					end
				end
				S_FRAC: begin
					wdiv_q <= 1'b0;
					cnt_q  <= '0;
					dq_q   <= '0;
					if (!radial_q) begin
						if (r1_q == '0) begin
							deg_q   <= 1'b1;
							at_q    <= '0;
							state_q <= S_LKA;
						end else if (r0_q <= 0) begin
							at_q    <= '0;
							state_q <= S_LKA;
						end else begin
							dnum_q  <= r0_q[DIV_W-1:0];
							dden_q  <= r1_q[DIV_W-1:0];
							state_q <= S_DIV;
						end
					end else begin
						if (r0_q == '0) begin
							deg_q   <= 1'b1;
							at_q    <= '0;
							state_q <= S_LKA;
						end else if (r3_q[ACC_W-1]) begin
							// ray misses the circle
							deg_q   <= 1'b1;
							at_q    <= ONE_Q16;
							state_q <= S_LKA;
						end else begin
							rad_q   <= r3_q;
							rem_q   <= '0;
							root_q  <= '0;
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					rad_q <= rad_q << 2;
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					if (cnt_q == 6'(ROOT_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_RDEN;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_RDEN: begin
					den_q   <= $signed({{(DIV_W-ROOT_W){1'b0}}, root_q})
						- $signed(r1_q[DIV_W-1:0]);
					state_q <= S_RCMP;
				end
				S_RCMP: begin
					if (den_q <= $signed(r0_q[DIV_W-1:0])) begin
						// hit behind or inside the point
						at_q    <= ONE_Q16;
						state_q <= S_LKA;
					end else begin
						dnum_q  <= r0_q[DIV_W-1:0];
						dden_q  <= den_q;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dnum_q <= dge ? (dsh - dden_q) : dsh;
					dq_q   <= dq_next;
					cnt_q  <= cnt_q + 6'd1;
					if (ddone) begin
						cnt_q <= '0;
						if (wdiv_q) begin
							w_q     <= dres;
							ch_q    <= '0;
							state_q <= S_BLEND;
						end else begin
							at_q    <= dres;
							state_q <= S_LKA;
						end
					end
				end
				S_LKA: begin
					if (count_q == '0) begin
						c1_q    <= '0;
						c2_q    <= '0;
						w_q     <= '0;
						ch_q    <= '0;
						state_q <= S_BLEND;
					end else begin
						state_q <= S_LKB;
					end
				end
				S_LKB: begin
					first_pos_q <= rd_pos;
					first_col_q <= rd_col;
					prev_pos_q  <= rd_pos;
					prev_col_q  <= rd_col;
					if (count_q == CW'(1)) begin
						c1_q    <= rd_col;
						c2_q    <= rd_col;
						w_q     <= '0;
						ch_q    <= '0;
						state_q <= S_BLEND;
					end else begin
						state_q <= S_LKC;
					end
				end
				S_LKC: begin
					if (wrap) begin
						// blend across the wrap from the last stop to the first
						c1_q   <= rd_col;
						c2_q   <= first_col_q;
						ch_q   <= '0;
						wdiv_q <= 1'b1;
						cnt_q  <= '0;
						dq_q   <= '0;
						dnum_q <= DIV_W'(unsigned'(w_off));
						dden_q <= DIV_W'(unsigned'(w_span));
						if (w_zero) begin
							w_q     <= '0;
							state_q <= S_BLEND;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						idx_q   <= CW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (bracket) begin
						c1_q   <= prev_col_q;
						c2_q   <= rd_col;
						ch_q   <= '0;
						wdiv_q <= 1'b1;
						cnt_q  <= '0;
						dq_q   <= '0;
						dnum_q <= DIV_W'(unsigned'(w_off));
						dden_q <= DIV_W'(unsigned'(w_span));
						if (w_zero) begin
							w_q     <= '0;
							state_q <= S_BLEND;
						end else begin
							state_q <= S_DIV;
						end
					end else if (idx_q + CW'(1) == count_q) begin
						// unsorted table with no bracketing pair
						c1_q    <= first_col_q;
						c2_q    <= first_col_q;
						w_q     <= '0;
						ch_q    <= '0;
						state_q <= S_BLEND;
					end else begin
						prev_pos_q <= rd_pos;
						prev_col_q <= rd_col;
						idx_q      <= idx_q + CW'(1);
					end
				end
				S_BLEND: begin
					if (ch_q != 2'd3) begin
						res_q[{ch_q, 3'b000} +: 8] <= bv;
						ch_q <= ch_q + 2'd1;
					end else if (!out_valid_q || m_tready) begin
						// hold on the last channel until the output register frees
						m_tdata_q   <= {bv, res_q[23:0]};
						m_tuser_q   <= deg_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`GCS_ASSERT(a_scan_idx, (state_q != S_SCAN) || (idx_q < count_q), "search index beyond stop count")
	`GCS_ASSERT(a_out_from_blend, !$rose(m_tvalid) || $past(state_q == S_BLEND), "result without blend")
	`GCS_ASSERT_NEXT(a_mul_end, (state_q == S_MUL) && (mplier_q == '0), (state_q == S_MSET) || (state_q == S_FRAC), "product sequencer lost")
	`GCS_ASSERT(a_count_cap, count_q <= CW'(MAX_STOPS), "stop count above table depth")

endmodule
`default_nettype wire
